@@ sv/rpg_pkg.sv @@
// Shared types and constants for the relay power guard.
// Used by the channel interfaces, the mode core and the top level.
`default_nettype none

package rpg_pkg;

    localparam int unsigned CNT_W   = 16;
    localparam int unsigned BLINK_W = 8;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE  = 3'd4;

    localparam logic [CNT_W-1:0]   RST_STARTUP = 16'd600;
    localparam logic [CNT_W-1:0]   RST_STOP    = 16'd200;
    localparam logic [CNT_W-1:0]   RST_RECOVER = 16'd300;
    localparam logic [BLINK_W-1:0] RST_BLINK   = 8'd3;
    localparam logic               RST_IGNORE  = 1'b1;

    // Mode codes as seen on the result channel
    localparam logic [CODE_W-1:0] CODE_POWERUP  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_RUNNING  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_PSDELAY  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_BLANKING = 3'd3;
    localparam logic [CODE_W-1:0] CODE_TRIPPED  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_SHORT    = 3'd5;

    typedef enum logic [5:0] {
        MODE_POWERUP  = 6'b000001,
        MODE_RUNNING  = 6'b000010,
        MODE_PSDELAY  = 6'b000100,
        MODE_BLANKING = 6'b001000,
        MODE_TRIPPED  = 6'b010000,
        MODE_SHORT    = 6'b100000
    } t_mode;

    typedef struct packed {
        logic off_request;
        logic short_fault;
    } t_in_item;

    typedef struct packed {
        logic              relay_cut;
        logic              green_led;
        logic              red_led;
        logic [CODE_W-1:0] mode_code;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]   startup_ticks;
        logic [CNT_W-1:0]   stop_ticks;
        logic [CNT_W-1:0]   recover_ticks;
        logic [BLINK_W-1:0] blink_ticks;
        logic               ignore_false_trip;
    } t_cfg;

    function automatic logic [CODE_W-1:0] mode_code(input t_mode m);
        logic [CODE_W-1:0] code;
        unique case (m)
            MODE_POWERUP:  code = CODE_POWERUP;
            MODE_RUNNING:  code = CODE_RUNNING;
            MODE_PSDELAY:  code = CODE_PSDELAY;
            MODE_BLANKING: code = CODE_BLANKING;
            MODE_TRIPPED:  code = CODE_TRIPPED;
            default:       code = CODE_SHORT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ sv/rpg_in_if.sv @@
// Tick request channel: valid/ready handshake with one input item.
// Depends on rpg_pkg for the payload type.
`default_nettype none

interface rpg_in_if;
    import rpg_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/rpg_out_if.sv @@
// Result channel: valid/ready handshake with one output item.
// Depends on rpg_pkg for the payload type.
`default_nettype none

interface rpg_out_if;
    import rpg_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/rpg_core.sv @@
// Mode state, delay and blink counters, LED and relay drive of the guard.
// Advances one tick per i_step; depends on rpg_pkg.
`default_nettype none

module rpg_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire rpg_pkg::t_in_item i_item,
    input  wire rpg_pkg::t_cfg     i_cfg,
    output rpg_pkg::t_out_item     o_item
);
    import rpg_pkg::*;

    t_mode              r_mode,  n_mode;
    logic [CNT_W-1:0]   r_delay, n_delay;
    logic [BLINK_W-1:0] r_blink, n_blink;
    logic               r_green, n_green;
    logic               r_red,   n_red;
    logic               r_relay, n_relay;

    t_mode              cur_mode;
    logic [CNT_W-1:0]   delay_inc;
    logic [BLINK_W-1:0] blink_inc;
    logic               blink_due;

    assign cur_mode  = i_item.short_fault ? MODE_SHORT : r_mode;
    assign delay_inc = (r_delay != CNT_MAX) ? r_delay + 1'b1 : r_delay;
    assign blink_inc = (r_blink != BLINK_MAX) ? r_blink + 1'b1 : r_blink;
    assign blink_due = blink_inc > i_cfg.blink_ticks;

    always_comb begin
        n_mode  = cur_mode;
        n_delay = r_delay;
        n_blink = r_blink;
        n_green = r_green;
        n_red   = r_red;
        n_relay = r_relay;

        unique case (cur_mode)
            MODE_POWERUP: begin
                n_relay = 1'b0;
                n_green = 1'b1;
                n_delay = delay_inc;
                n_blink = blink_due ? '0 : blink_inc;
                if (blink_due) begin
                    n_red = ~r_red;
                end
                if (delay_inc > i_cfg.startup_ticks) begin
                    n_mode  = i_item.off_request ? MODE_BLANKING : MODE_RUNNING;
                    n_green = 1'b0;
                    n_red   = 1'b0;
                    n_delay = '0;
                    n_blink = '0;
                end
            end
            MODE_RUNNING: begin
                n_relay = 1'b0;
                n_red   = 1'b0;
                n_green = 1'b1;
                n_delay = '0;
                n_blink = '0;
                if (i_item.off_request) begin
                    n_mode  = MODE_PSDELAY;
                    n_green = 1'b0;
                end
            end
            MODE_PSDELAY: begin
                n_relay = 1'b0;
                n_red   = 1'b0;
                n_delay = delay_inc;
                n_blink = blink_due ? '0 : blink_inc;
                if (blink_due) begin
                    n_green = ~r_green;
                end
                if (delay_inc > i_cfg.stop_ticks) begin
                    // a request gone by timeout counts as a false trip
                    n_mode  = (i_cfg.ignore_false_trip && !i_item.off_request)
                              ? MODE_RUNNING : MODE_BLANKING;
                    n_green = 1'b0;
                    n_delay = '0;
                    n_blink = '0;
                end
            end
            MODE_BLANKING: begin
                n_relay = 1'b1;
                n_delay = delay_inc;
                n_blink = blink_due ? '0 : blink_inc;
                if (blink_due) begin
                    n_red   = ~r_red;
                    n_green = ~r_green;
                end
                if (delay_inc > i_cfg.recover_ticks) begin
                    n_green = 1'b0;
                    n_red   = 1'b0;
                    n_delay = '0;
                    n_blink = '0;
                    if (i_item.off_request) begin
                        n_mode = MODE_TRIPPED;
                    end else begin
                        n_mode  = MODE_POWERUP;
                        n_relay = 1'b0;
                    end
                end
            end
            MODE_TRIPPED: begin
                n_relay = 1'b1;
                n_red   = 1'b1;
                n_green = 1'b0;
                if (!i_item.off_request) begin
                    n_mode  = MODE_POWERUP;
                    n_relay = 1'b0;
                    n_red   = 1'b0;
                    n_delay = '0;
                    n_blink = '0;
                end
            end
            default: begin
                n_mode  = MODE_SHORT;
                n_relay = 1'b1;
                n_delay = '0;
                n_blink = blink_due ? '0 : blink_inc;
                // alternate the two LEDs, green leading
                if (blink_due) begin
                    n_red   = r_green;
                    n_green = ~r_green;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_POWERUP;
            r_delay <= '0;
            r_blink <= '0;
            r_green <= 1'b0;
            r_red   <= 1'b0;
            r_relay <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_delay <= n_delay;
            r_blink <= n_blink;
            r_green <= n_green;
            r_red   <= n_red;
            r_relay <= n_relay;
        end
    end

    assign o_item.relay_cut = r_relay;
    assign o_item.green_led = r_green;
    assign o_item.red_led   = r_red;
    assign o_item.mode_code = mode_code(r_mode);

endmodule

`default_nettype wire

@@ sv/relay_power_guard_fsm.sv @@
// Top level of the relay power guard: handshake, input register, config registers.
// Depends on rpg_pkg, rpg_in_if, rpg_out_if and rpg_core.
//
//   channel   direction  payload                                     handshake
//   i_in      in         off_request, short_fault                    valid/ready
//   o_out     out        relay_cut, green_led, red_led, mode_code    valid/ready
//   i_cfg_*   in         index 0..4, data 16 bit                     write enable
//
// One request per cycle sustained while o_out.ready is high; a result is valid on
// o_out once its request passes the input register, then the result registers (mode/counter).
// The result register holds while o_out.ready is low; the input register takes one
// more request and then i_in.ready drops until the result drains.
// Reset is synchronous, holds i_in.ready low and restores the register defaults
// and powerup mode.
`default_nettype none

module relay_power_guard_fsm (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    rpg_in_if.sink                            i_in,
    rpg_out_if.source                         o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [rpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rpg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rpg_pkg::*;

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    logic     step;

    // advance the held request into the state when the result slot is free
    assign step        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = i_rst_n && (!r_in_valid || step);
    assign o_out.valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_ticks     <= RST_STARTUP;
            r_cfg.stop_ticks        <= RST_STOP;
            r_cfg.recover_ticks     <= RST_RECOVER;
            r_cfg.blink_ticks       <= RST_BLINK;
            r_cfg.ignore_false_trip <= RST_IGNORE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STARTUP: r_cfg.startup_ticks     <= i_cfg_data;
                CFG_STOP:    r_cfg.stop_ticks        <= i_cfg_data;
                CFG_RECOVER: r_cfg.recover_ticks     <= i_cfg_data;
                CFG_BLINK:   r_cfg.blink_ticks       <= i_cfg_data[BLINK_W-1:0];
                CFG_IGNORE:  r_cfg.ignore_false_trip <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    rpg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_item  (o_out.data)
    );

endmodule

`default_nettype wire
